// File: hw/rtl/cfmp_pkg.sv
// ----------------------------------------------------------------------------
// cfmp_pkg
// Shared types and constants for the command FIFO method parser.
// ----------------------------------------------------------------------------
package cfmp_pkg;

  localparam int NUM_TEX_UNITS   = 16;
  localparam int NUM_VTX_ATTRIBS = 16;

  localparam int WORD_W  = 32;
  localparam int ADDR_W  = 14;
  localparam int COUNT_W = 11;

  // header types
  localparam logic [2:0] HDR_INC    = 3'd0;
  localparam logic [2:0] HDR_NONINC = 3'd2;

  // result kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_STOP  = 1'b1;

  // target classes
  localparam logic [2:0] TGT_SURFACE = 3'd0;
  localparam logic [2:0] TGT_TEXTURE = 3'd1;
  localparam logic [2:0] TGT_VFMT    = 3'd2;
  localparam logic [2:0] TGT_VOFS    = 3'd3;
  localparam logic [2:0] TGT_OTHER   = 3'd4;

  // method address map
  localparam logic [ADDR_W-1:0] SURF_LO   = 14'h0200;
  localparam logic [ADDR_W-1:0] SURF_HI   = 14'h023C;
  localparam logic [ADDR_W-1:0] TEX_BASE  = 14'h1A00;
  localparam logic [ADDR_W-1:0] TEX_END   = ADDR_W'(32'h1A00 + NUM_TEX_UNITS * 32'h20);
  localparam logic [ADDR_W-1:0] VFMT_BASE = 14'h1740;
  localparam logic [ADDR_W-1:0] VFMT_END  = ADDR_W'(32'h1740 + NUM_VTX_ATTRIBS * 4);
  localparam logic [ADDR_W-1:0] VOFS_BASE = 14'h1680;
  localparam logic [ADDR_W-1:0] VOFS_END  = ADDR_W'(32'h1680 + NUM_VTX_ATTRIBS * 4);

  typedef struct packed {
    logic [2:0] target;
    logic [3:0] index;
    logic [2:0] reg_slot;
  } class_t;

  typedef struct packed {
    logic              kind;
    logic [2:0]        stop_type;
    logic [ADDR_W-1:0] method_addr;
    logic [WORD_W-1:0] method_data;
    class_t            cls;
    logic [WORD_W-1:0] processed_count;
  } result_t;

endpackage

// File: hw/rtl/cfmp_classify.sv
// ----------------------------------------------------------------------------
// cfmp_classify
// Decodes a method byte address into its target class, index and slot.
// ----------------------------------------------------------------------------
module cfmp_classify (
  input  logic [cfmp_pkg::ADDR_W-1:0] addr,
  output cfmp_pkg::class_t            cls
);

  logic [cfmp_pkg::ADDR_W-1:0] tex_off;
  logic [cfmp_pkg::ADDR_W-1:0] vfmt_off;
  logic [cfmp_pkg::ADDR_W-1:0] vofs_off;

  assign tex_off  = addr - cfmp_pkg::TEX_BASE;
  assign vfmt_off = addr - cfmp_pkg::VFMT_BASE;
  assign vofs_off = addr - cfmp_pkg::VOFS_BASE;

  // ranges are checked in priority order
  always_comb begin
    cls.target   = cfmp_pkg::TGT_OTHER;
    cls.index    = 4'd0;
    cls.reg_slot = 3'd0;
    if (addr >= cfmp_pkg::SURF_LO && addr <= cfmp_pkg::SURF_HI) begin
      cls.target = cfmp_pkg::TGT_SURFACE;
    end else if (addr >= cfmp_pkg::TEX_BASE && addr < cfmp_pkg::TEX_END) begin
      cls.target   = cfmp_pkg::TGT_TEXTURE;
      cls.index    = tex_off[8:5];
      cls.reg_slot = tex_off[4:2];
    end else if (addr >= cfmp_pkg::VFMT_BASE && addr < cfmp_pkg::VFMT_END) begin
      cls.target = cfmp_pkg::TGT_VFMT;
      cls.index  = vfmt_off[5:2];
    end else if (addr >= cfmp_pkg::VOFS_BASE && addr < cfmp_pkg::VOFS_END) begin
      cls.target = cfmp_pkg::TGT_VOFS;
      cls.index  = vofs_off[5:2];
    end
  end

endmodule

// File: hw/rtl/cfmp_parse.sv
// ----------------------------------------------------------------------------
// cfmp_parse
// Input word register and header/data parse state; builds one result.
// ----------------------------------------------------------------------------
module cfmp_parse (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [cfmp_pkg::WORD_W-1:0] cmd_word,
  input  logic                        buf_start,
  input  logic                        res_free,   // result register can load
  output logic                        res_load,
  output cfmp_pkg::result_t           res
);

  logic                         word_vld;
  logic [cfmp_pkg::WORD_W-1:0]  word;
  logic                         start;

  logic [cfmp_pkg::COUNT_W-1:0] words_left, words_left_next;
  logic [cfmp_pkg::ADDR_W-1:0]  cur_method, cur_method_next;
  logic                         step_up, step_up_next;
  logic                         halted, halted_next;
  logic [cfmp_pkg::WORD_W-1:0]  method_count, method_count_next;

  logic [cfmp_pkg::COUNT_W-1:0] eff_left;
  logic [cfmp_pkg::ADDR_W-1:0]  eff_method;
  logic                         eff_step;
  logic                         eff_halted;
  logic [cfmp_pkg::WORD_W-1:0]  eff_count;
  logic [2:0]                   hdr_type;
  logic                         proc;
  logic                         has_res;
  cfmp_pkg::class_t             cls;

  assign proc     = word_vld && res_free;
  assign in_ready = !word_vld || proc;
  assign res_load = proc && has_res;
  assign hdr_type = word[31:29];

  // a buffer start clears the parser before the word is used
  assign eff_left   = start ? '0 : words_left;
  assign eff_method = start ? '0 : cur_method;
  assign eff_step   = start ? 1'b0 : step_up;
  assign eff_halted = start ? 1'b0 : halted;
  assign eff_count  = start ? '0 : method_count;

  cfmp_classify u_classify (
    .addr (eff_method),
    .cls  (cls)
  );

  always_comb begin
    words_left_next   = eff_left;
    cur_method_next   = eff_method;
    step_up_next      = eff_step;
    halted_next       = eff_halted;
    method_count_next = eff_count;
    has_res           = 1'b0;
    res               = '0;
    res.processed_count = eff_count;
    if (eff_halted) begin
      has_res = 1'b0;
    end else if (eff_left == '0) begin
      if (hdr_type == cfmp_pkg::HDR_INC || hdr_type == cfmp_pkg::HDR_NONINC) begin
        words_left_next = word[28:18];
        cur_method_next = {word[12:2], 2'b00};
        step_up_next    = (hdr_type == cfmp_pkg::HDR_INC);
      end else begin
        halted_next     = 1'b1;
        words_left_next = '0;
        has_res         = 1'b1;
        res.kind        = cfmp_pkg::KIND_STOP;
        res.stop_type   = hdr_type;
      end
    end else begin
      method_count_next   = eff_count + 1'b1;
      words_left_next     = eff_left - 1'b1;
      if (eff_step) begin
        cur_method_next = eff_method + cfmp_pkg::ADDR_W'(4);
      end
      has_res             = 1'b1;
      res.kind            = cfmp_pkg::KIND_WRITE;
      res.method_addr     = eff_method;
      res.method_data     = word;
      res.cls             = cls;
      res.processed_count = method_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_vld     <= 1'b0;
      words_left   <= '0;
      cur_method   <= '0;
      step_up      <= 1'b0;
      halted       <= 1'b0;
      method_count <= '0;
    end else begin
      if (in_ready) begin
        word_vld <= in_valid;
      end
      if (proc) begin
        words_left   <= words_left_next;
        cur_method   <= cur_method_next;
        step_up      <= step_up_next;
        halted       <= halted_next;
        method_count <= method_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      word  <= cmd_word;
      start <= buf_start;
    end
  end

endmodule

// File: hw/rtl/gpu_command_fifo_method_parser.sv
// ----------------------------------------------------------------------------
// gpu_command_fifo_method_parser
// Parses command-buffer words into method writes with target decode, and stop results.
// ----------------------------------------------------------------------------
// One word is taken per clock while the output register is free. Each accepted
// word is held in an input register and parsed against the header state, and
// its result (if any) is loaded into the output register, which presents it.
// Headers and ignored words give no result, but they also wait while the
// output register holds an unread result. The input register frees whenever
// the output register is empty or being read, so the rate stays one word per
// cycle as long as results are taken.
module gpu_command_fifo_method_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] cmd_word,
  input  logic        buf_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        kind,
  output logic [2:0]  stop_type,
  output logic [13:0] method_addr,
  output logic [31:0] method_data,
  output logic [2:0]  target,
  output logic [3:0]  target_index,
  output logic [2:0]  target_reg,
  output logic [31:0] processed_count
);

  logic              res_free;
  logic              res_load;
  cfmp_pkg::result_t res;
  cfmp_pkg::result_t res_q;

  assign res_free = !out_valid || out_ready;

  cfmp_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd_word  (cmd_word),
    .buf_start (buf_start),
    .res_free  (res_free),
    .res_load  (res_load),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_free) begin
      out_valid <= res_load;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_q <= res;
    end
  end

  assign kind            = res_q.kind;
  assign stop_type       = res_q.stop_type;
  assign method_addr     = res_q.method_addr;
  assign method_data     = res_q.method_data;
  assign target          = res_q.cls.target;
  assign target_index    = res_q.cls.index;
  assign target_reg      = res_q.cls.reg_slot;
  assign processed_count = res_q.processed_count;

endmodule
